// ----- design/sitda_pkg.sv -----
`default_nettype none
// -----------------------------------------------------------------------------
// sitda_pkg
// Shared constants and controller/datapath interface types for the signed
// integer to decimal text converter.
// -----------------------------------------------------------------------------
package sitda_pkg;

  localparam int unsigned VALUE_BITS_DEF = 32;

  localparam logic [7:0] ASCII_ZERO  = 8'd48;
  localparam logic [7:0] ASCII_NINE  = 8'd57;
  localparam logic [7:0] ASCII_MINUS = 8'd45;

  // Double-dabble correction: a BCD digit of five or more gets three added
  // before the shift, so that it carries correctly into the next digit.
  localparam logic [3:0] BCD_ADJ_MIN = 4'd5;
  localparam logic [3:0] BCD_ADJ     = 4'd3;

  typedef struct packed {
    logic load;        // take a new value and form its magnitude
    logic conv_step;   // one binary-to-BCD shift step
    logic cnt_clr;     // clear the step/digit counter
    logic dig_shift;   // drop the top BCD digit
    logic push_minus;  // load '-' into the output register
    logic push_digit;  // load the top digit into the output register
  } sitda_cmd_t;

  typedef struct packed {
    logic neg;
    logic conv_done;
    logic dig_last;
    logic top_zero;
    logic out_free;
  } sitda_sts_t;

endpackage
`default_nettype wire

// ----- design/sitda_dp.sv -----
`default_nettype none
// -----------------------------------------------------------------------------
// sitda_dp
// Datapath: magnitude, serial double-dabble BCD converter, step counter and
// the output register.
// -----------------------------------------------------------------------------
module sitda_dp import sitda_pkg::*; #(
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic signed [VALUE_BITS-1:0] value_i,
  input  wire sitda_cmd_t                   cmd_i,
  output sitda_sts_t                        sts_o,
  input  wire logic                         out_stall_i,
  output logic                              out_valid_o,
  output logic [7:0]                        character_o,
  output logic                              last_char_o
);

  // Decimal digits needed for VALUE_BITS unsigned bits (log10(2) ~ 0.30103).
  localparam int unsigned NUM_DIGITS = (VALUE_BITS * 30103) / 100000 + 1;
  localparam int unsigned BCD_W      = 4 * NUM_DIGITS;
  localparam int unsigned CNT_W      = $clog2(VALUE_BITS);

  logic                  neg_q, neg_d;
  logic [VALUE_BITS-1:0] bin_q, bin_d;
  logic [BCD_W-1:0]      bcd_q, bcd_d;
  logic [BCD_W-1:0]      bcd_adj;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic                  out_valid_q, out_valid_d;
  logic [7:0]            char_q, char_d;
  logic                  last_q, last_d;
  logic [VALUE_BITS-1:0] mag;
  logic [3:0]            top_digit;
  logic                  out_free;

  // Unsigned magnitude; the most negative value maps to 2^(VALUE_BITS-1).
  assign mag       = value_i[VALUE_BITS-1] ? (VALUE_BITS'(0) - VALUE_BITS'(value_i))
                                           : VALUE_BITS'(value_i);
  assign top_digit = bcd_q[BCD_W-1 -: 4];
  assign out_free  = !out_valid_q || !out_stall_i;

  always_comb begin
    bcd_adj = bcd_q;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (bcd_q[4*i +: 4] >= BCD_ADJ_MIN) begin
        bcd_adj[4*i +: 4] = bcd_q[4*i +: 4] + BCD_ADJ;
      end
    end
  end

  always_comb begin
    neg_d = neg_q;
    bin_d = bin_q;
    bcd_d = bcd_q;
    if (cmd_i.load) begin
      neg_d = value_i[VALUE_BITS-1];
      bin_d = mag;
      bcd_d = '0;
    end else if (cmd_i.conv_step) begin
      bcd_d = {bcd_adj[BCD_W-2:0], bin_q[VALUE_BITS-1]};
      bin_d = {bin_q[VALUE_BITS-2:0], 1'b0};
    end else if (cmd_i.dig_shift) begin
      bcd_d = {bcd_q[BCD_W-5:0], 4'h0};
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.load || cmd_i.cnt_clr) begin
      cnt_d = '0;
    end else if (cmd_i.conv_step || cmd_i.dig_shift) begin
      cnt_d = cnt_q + CNT_W'(1);
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    char_d      = char_q;
    last_d      = last_q;
    if (out_free) begin
      out_valid_d = cmd_i.push_minus || cmd_i.push_digit;
    end
    if (cmd_i.push_minus) begin
      char_d = ASCII_MINUS;
      last_d = 1'b0;
    end else if (cmd_i.push_digit) begin
      char_d = ASCII_ZERO + {4'h0, top_digit};
      last_d = (cnt_q == CNT_W'(NUM_DIGITS - 1));
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q  <= neg_d;
    bin_q  <= bin_d;
    bcd_q  <= bcd_d;
    char_q <= char_d;
    last_q <= last_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign sts_o.neg       = neg_q;
  assign sts_o.conv_done = (cnt_q == CNT_W'(VALUE_BITS - 1));
  assign sts_o.dig_last  = (cnt_q == CNT_W'(NUM_DIGITS - 1));
  assign sts_o.top_zero  = (top_digit == 4'h0);
  assign sts_o.out_free  = out_free;

  assign out_valid_o = out_valid_q;
  assign character_o = char_q;
  assign last_char_o = last_q;

endmodule
`default_nettype wire

// ----- design/sitda_ctrl.sv -----
`default_nettype none
// -----------------------------------------------------------------------------
// sitda_ctrl
// Controller: sequences conversion, sign output, leading-zero skip and
// digit output for one value at a time.
// -----------------------------------------------------------------------------
module sitda_ctrl import sitda_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire sitda_sts_t sts_i,
  output sitda_cmd_t      cmd_o
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_CONV = 3'd1;
  localparam logic [2:0] ST_SIGN = 3'd2;
  localparam logic [2:0] ST_SKIP = 3'd3;
  localparam logic [2:0] ST_EMIT = 3'd4;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_CONV;
        end
      end
      ST_CONV: begin
        cmd_o.conv_step = 1'b1;
        if (sts_i.conv_done) begin
          cmd_o.cnt_clr = 1'b1;
          state_d       = sts_i.neg ? ST_SIGN : ST_SKIP;
        end
      end
      ST_SIGN: begin
        if (sts_i.out_free) begin
          cmd_o.push_minus = 1'b1;
          state_d          = ST_SKIP;
        end
      end
      ST_SKIP: begin
        // The lowest digit is always shown, so zero still gives one '0'.
        if (sts_i.top_zero && !sts_i.dig_last) begin
          cmd_o.dig_shift = 1'b1;
        end else begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.push_digit = 1'b1;
          cmd_o.dig_shift  = 1'b1;
          if (sts_i.dig_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

// ----- design/signed_int_to_decimal_ascii.sv -----
`default_nettype none
// -----------------------------------------------------------------------------
// signed_int_to_decimal_ascii
// Converts one signed integer into its decimal ASCII text, one character per
// output transaction, most significant digit first, with last_char_o set on
// the final character.
// -----------------------------------------------------------------------------
// One value is converted at a time. After a value is accepted, a serial
// double-dabble unit turns the magnitude into BCD one bit per cycle, a '-'
// goes out for a negative value, leading zero digits are dropped at one per
// cycle, and then one character leaves per cycle while the output is not
// stalled. The output register holds the last character while the next
// value is being taken in.
module signed_int_to_decimal_ascii import sitda_pkg::*; #(
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic signed [VALUE_BITS-1:0] value_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic [7:0]                        character_o,
  output logic                              last_char_o
);

  sitda_cmd_t cmd;
  sitda_sts_t sts;

  sitda_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  sitda_dp #(
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .value_i     (value_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .character_o (character_o),
    .last_char_o (last_char_o)
  );

endmodule
`default_nettype wire

// ----- design/sitda_chk.sv -----
`default_nettype none
// -----------------------------------------------------------------------------
// sitda_chk
// Port-level checks for the decimal text converter, bound to the top level.
// -----------------------------------------------------------------------------
module sitda_chk import sitda_pkg::*; (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_stall_o,
  input wire logic       out_valid_o,
  input wire logic       out_stall_i,
  input wire logic [7:0] character_o,
  input wire logic       last_char_o
);

  // A stalled output transaction keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(character_o)
                                   && $stable(last_char_o))
    else $error("stalled output changed");

  // Only '-' and decimal digits are ever produced.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> character_o == ASCII_MINUS
                    || (character_o >= ASCII_ZERO && character_o <= ASCII_NINE))
    else $error("character out of range");

  // The sign never ends a number's text.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && character_o == ASCII_MINUS |-> !last_char_o)
    else $error("minus sign marked last");

  // After a value is taken the block is busy converting it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken during conversion");

endmodule

bind signed_int_to_decimal_ascii sitda_chk u_sitda_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .character_o (character_o),
  .last_char_o (last_char_o)
);
`default_nettype wire

// ----- tb/signed_int_to_decimal_ascii_tb.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_tb
// Sends signed 32-bit values into the converter and checks every character
// it emits, including the last-character flag, against text worked out here.
// It covers directed corner values, random values of every length, random
// idling on both sides and a long output hold that backs up the input.
// -----------------------------------------------------------------------------
module signed_int_to_decimal_ascii_tb;
  import sitda_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned DRAIN_CYCLES = 60;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } text_char_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic signed [31:0] value = '0;
  logic               out_stall = 1'b0;
  logic               stall_hold = 1'b0;
  wire                in_stall;
  wire                out_valid;
  wire  [7:0]         character;
  wire                last_char;

  text_char_t  expected_text[$];
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned mismatch_count = 0;
  int unsigned values_sent = 0;
  int unsigned chars_checked = 0;
  int unsigned cycle_count = 0;
  event        hold_go;

  signed_int_to_decimal_ascii uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .value_i    (value),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .character_o(character),
    .last_char_o(last_char)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("Mismatches found");
      $finish;
    end
  end

  // Receiver: random stall, forced high during a long hold.
  always @(posedge clk) begin
    out_stall <= stall_hold || ($urandom_range(99) < recv_idle_pct);
  end

  initial begin : receiver_hold
    forever begin
      @(hold_go);
      stall_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      stall_hold <= 1'b0;
    end
  end

  // Works out the decimal text of one value and queues its characters.
  task automatic predict_text(input logic signed [31:0] v);
    logic [31:0] mag;
    logic [3:0]  digits[$];
    text_char_t  c;
    mag = v[31] ? (~v + 32'd1) : v;
    do begin
      digits.push_front(4'(mag % 10));
      mag = mag / 10;
    end while (mag != 0);
    if (v[31]) begin
      c.ch = ASCII_MINUS;
      c.last = 1'b0;
      expected_text.push_back(c);
    end
    foreach (digits[i]) begin
      c.ch = ASCII_ZERO + 8'(digits[i]);
      c.last = (i == digits.size() - 1);
      expected_text.push_back(c);
    end
  endtask

  // Offers one value and returns at the edge where it was taken.
  task automatic send_value(input logic signed [31:0] v);
    logic taken;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 50)) @(posedge clk);
    end
    in_valid <= 1'b1;
    value <= v;
    // The stall only moves at a rising edge, so the level seen at the
    // falling edge is the one that the next rising edge acts on.
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
    predict_text(v);
    values_sent++;
  endtask

  function automatic logic signed [31:0] random_value();
    longint unsigned mag;
    longint unsigned span;
    logic            neg;
    int unsigned     kind;
    neg = $urandom_range(1);
    kind = $urandom_range(9);
    span = 1;
    repeat ($urandom_range(kind == 2 ? 0 : 1, 10)) span = span * 10;
    case (kind)
      0, 1: return $urandom();
      2: mag = span + $urandom_range(2) - 1;
      3: begin
        case ($urandom_range(3))
          0: return 32'sh0000_0000;
          1: return 32'sh8000_0000;
          2: return 32'sh7fff_ffff;
          default: return 32'shffff_ffff;
        endcase
      end
      default: mag = {32'd0, $urandom()} % span;
    endcase
    if (neg && mag > 64'd2147483648) mag = 64'd2147483648;
    if (!neg && mag > 64'd2147483647) mag = 64'd2147483647;
    return neg ? 32'(64'd0 - mag) : 32'(mag);
  endfunction

  // Output ports and the stall are steady at the falling edge, so a
  // transaction seen there is the one the following rising edge accepts.
  initial begin : check_text
    text_char_t exp_c;
    forever begin
      @(negedge clk);
      if (rst_n && out_valid && !out_stall) begin
        if (expected_text.size() == 0) begin
          $display("%0t: unexpected character, expected none, actual %0d last %b",
                   $time, character, last_char);
          mismatch_count++;
        end else begin
          exp_c = expected_text.pop_front();
          chars_checked++;
          if (character !== exp_c.ch) begin
            $display("%0t: character expected %0d actual %0d",
                     $time, exp_c.ch, character);
            mismatch_count++;
          end
          if (last_char !== exp_c.last) begin
            $display("%0t: last_char expected %b actual %b",
                     $time, exp_c.last, last_char);
            mismatch_count++;
          end
        end
      end
    end
  end

  task automatic test_directed();
    logic signed [31:0] corner[] = '{
      32'sd0, 32'sd1, -32'sd1, 32'sd9, -32'sd9, 32'sd10, -32'sd10, 32'sd99,
      32'sd100, 32'sd1000000000, -32'sd1000000000, 32'sd999999999,
      32'sd2147483647, -32'sd2147483647, 32'sh8000_0000, 32'sd123456789,
      -32'sd987654321, 32'sd1073741824, 32'sh5555_5555, 32'shaaaa_aaaa,
      32'sd100000, -32'sd99999
    };
    foreach (corner[i]) send_value(corner[i]);
  endtask

  task automatic test_random(input int unsigned count);
    repeat (count) send_value(random_value());
  endtask

  // The output is held for a long stretch while values keep coming, so
  // the converter fills up and must stall its input.
  task automatic test_backpressure();
    -> hold_go;
    repeat (8) send_value(random_value());
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 16;
    recv_idle_pct = 50;
    test_directed();
    test_random(130);

    send_idle_pct = 50;
    recv_idle_pct = 16;
    test_random(140);
    test_backpressure();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(130);
    in_valid <= 1'b0;

    while (expected_text.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Converted %0d values, %0d characters checked, in %0d cycles.",
             values_sent, chars_checked, cycle_count);
    $display("Included corner values, random idling on both sides and a %0d-cycle hold.",
             HOLD_CYCLES);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
